// ===== src/i2c_master_bit_engine_assert.svh =====
// Assertion macros used by the I2C master bit engine RTL.
`ifndef I2C_MASTER_BIT_ENGINE_ASSERT_SVH
`define I2C_MASTER_BIT_ENGINE_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define I2CM_ASSERT_IMP(lbl, clk, rst_n, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("i2cm assertion failed");

// Next-cycle implication, checked out of reset.
`define I2CM_ASSERT_NXT(lbl, clk, rst_n, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("i2cm assertion failed");

`endif

// ===== src/i2cm_pkg.sv =====
// Types, command codes and the microcode ROM of the I2C master bit engine.
`timescale 1ns / 1ps
package i2cm_pkg;

    localparam int UPC_W = 5;
    localparam int CNT_W = 3;
    localparam logic [CNT_W-1:0] BIT_CNT_INIT = 3'd7;

    typedef enum logic [2:0] {
        CMD_START  = 3'd0,
        CMD_STOP   = 3'd1,
        CMD_WRITE  = 3'd2,
        CMD_READ   = 3'd3,
        CMD_TX_ACK = 3'd4,
        CMD_RX_ACK = 3'd5
    } t_cmd;

    typedef enum logic [1:0] {SCL_HOLD, SCL_LOW, SCL_HIGH} t_scl_op;
    typedef enum logic [2:0] {SDA_HOLD, SDA_LOW, SDA_HIGH, SDA_ACK, SDA_MSB} t_sda_op;
    typedef enum logic [1:0] {SH_NONE, SH_LEFT, SH_IN} t_shift_op;
    typedef enum logic [1:0] {SEQ_NEXT, SEQ_END, SEQ_LOOP} t_seq_op;

    typedef struct packed {
        t_scl_op          scl_op;
        t_sda_op          sda_op;
        t_shift_op        shift_op;
        t_seq_op          seq_op;
        logic [UPC_W-1:0] target;
        logic             rx_byte;
        logic             rx_ack;
    } t_uword;

    // Step status from the sequencer to the datapath.
    typedef struct packed {
        logic   step;
        logic   last;
        t_uword uw;
    } t_ctrl;

    localparam logic [UPC_W-1:0] A_START  = 5'd0;
    localparam logic [UPC_W-1:0] A_STOP   = 5'd4;
    localparam logic [UPC_W-1:0] A_WRITE  = 5'd7;
    localparam logic [UPC_W-1:0] A_READ   = 5'd10;
    localparam logic [UPC_W-1:0] A_RD_BIT = 5'd11;
    localparam logic [UPC_W-1:0] A_TX_ACK = 5'd13;
    localparam logic [UPC_W-1:0] A_RX_ACK = 5'd16;

    function automatic t_uword uw(t_scl_op scl, t_sda_op sda, t_shift_op sh,
                                  t_seq_op seq, logic [UPC_W-1:0] tgt,
                                  logic rxb, logic rxa);
        t_uword w;
        w.scl_op   = scl;
        w.sda_op   = sda;
        w.shift_op = sh;
        w.seq_op   = seq;
        w.target   = tgt;
        w.rx_byte  = rxb;
        w.rx_ack   = rxa;
        return w;
    endfunction

    // One control word per line phase.
    function automatic t_uword ucode_rom(logic [UPC_W-1:0] pc);
        t_uword w;
        unique case (pc)
            5'd0:  w = uw(SCL_HOLD, SDA_HIGH, SH_NONE, SEQ_NEXT, '0, 1'b0, 1'b0);
            5'd1:  w = uw(SCL_HIGH, SDA_HOLD, SH_NONE, SEQ_NEXT, '0, 1'b0, 1'b0);
            5'd2:  w = uw(SCL_HOLD, SDA_LOW,  SH_NONE, SEQ_NEXT, '0, 1'b0, 1'b0);
            5'd3:  w = uw(SCL_LOW,  SDA_HOLD, SH_NONE, SEQ_END,  '0, 1'b0, 1'b0);
            5'd4:  w = uw(SCL_HOLD, SDA_LOW,  SH_NONE, SEQ_NEXT, '0, 1'b0, 1'b0);
            5'd5:  w = uw(SCL_HIGH, SDA_HOLD, SH_NONE, SEQ_NEXT, '0, 1'b0, 1'b0);
            5'd6:  w = uw(SCL_HOLD, SDA_HIGH, SH_NONE, SEQ_END,  '0, 1'b0, 1'b0);
            5'd7:  w = uw(SCL_HOLD, SDA_MSB,  SH_LEFT, SEQ_NEXT, '0, 1'b0, 1'b0);
            5'd8:  w = uw(SCL_HIGH, SDA_HOLD, SH_NONE, SEQ_NEXT, '0, 1'b0, 1'b0);
            5'd9:  w = uw(SCL_LOW,  SDA_HOLD, SH_NONE, SEQ_LOOP, A_WRITE, 1'b0, 1'b0);
            5'd10: w = uw(SCL_HOLD, SDA_HIGH, SH_NONE, SEQ_NEXT, '0, 1'b0, 1'b0);
            5'd11: w = uw(SCL_HIGH, SDA_HOLD, SH_IN,   SEQ_NEXT, '0, 1'b0, 1'b0);
            5'd12: w = uw(SCL_LOW,  SDA_HOLD, SH_NONE, SEQ_LOOP, A_RD_BIT, 1'b1, 1'b0);
            5'd13: w = uw(SCL_HOLD, SDA_ACK,  SH_NONE, SEQ_NEXT, '0, 1'b0, 1'b0);
            5'd14: w = uw(SCL_HIGH, SDA_HOLD, SH_NONE, SEQ_NEXT, '0, 1'b0, 1'b0);
            5'd15: w = uw(SCL_LOW,  SDA_HOLD, SH_NONE, SEQ_END,  '0, 1'b0, 1'b0);
            5'd16: w = uw(SCL_HOLD, SDA_HIGH, SH_NONE, SEQ_NEXT, '0, 1'b0, 1'b0);
            5'd17: w = uw(SCL_HIGH, SDA_HOLD, SH_NONE, SEQ_NEXT, '0, 1'b0, 1'b0);
            5'd18: w = uw(SCL_LOW,  SDA_HOLD, SH_NONE, SEQ_END,  '0, 1'b0, 1'b1);
            default: w = uw(SCL_HOLD, SDA_HOLD, SH_NONE, SEQ_END, '0, 1'b0, 1'b0);
        endcase
        return w;
    endfunction

    function automatic logic cmd_known(logic [2:0] code);
        return (code <= CMD_RX_ACK);
    endfunction

    function automatic logic [UPC_W-1:0] cmd_entry(logic [2:0] code);
        logic [UPC_W-1:0] a;
        unique case (code)
            CMD_START:  a = A_START;
            CMD_STOP:   a = A_STOP;
            CMD_WRITE:  a = A_WRITE;
            CMD_READ:   a = A_READ;
            CMD_TX_ACK: a = A_TX_ACK;
            CMD_RX_ACK: a = A_RX_ACK;
            default:    a = A_START;
        endcase
        return a;
    endfunction

endpackage

// ===== src/i2cm_sequencer.sv =====
// Microcode sequencer: step counter, bit loop counter and ROM fetch.
`timescale 1ns / 1ps
module i2cm_sequencer
    import i2cm_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_launch,
    input  logic [2:0]       i_cmd,
    input  logic             i_slot_free,
    output logic             o_busy,
    output t_ctrl            o_ctrl
);

    logic [UPC_W-1:0] r_pc, n_pc;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_busy, n_busy;
    t_uword           w_uw;
    logic             w_step;
    logic             w_last;

    assign w_uw   = ucode_rom(r_pc);
    assign w_step = r_busy && i_slot_free;
    assign w_last = (w_uw.seq_op == SEQ_END) ||
                    ((w_uw.seq_op == SEQ_LOOP) && (r_cnt == '0));

    always_comb begin
        n_pc   = r_pc;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        if (i_launch) begin
            n_pc   = cmd_entry(i_cmd);
            n_cnt  = BIT_CNT_INIT;
            n_busy = 1'b1;
        end else if (w_step) begin
            case (w_uw.seq_op)
                SEQ_NEXT: n_pc = UPC_W'(r_pc + 1'b1);
                SEQ_LOOP: begin
                    if (r_cnt != '0) begin
                        n_pc  = w_uw.target;
                        n_cnt = CNT_W'(r_cnt - 1'b1);
                    end else begin
                        n_busy = 1'b0;
                    end
                end
                default: n_busy = 1'b0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc   <= '0;
            r_cnt  <= '0;
            r_busy <= 1'b0;
        end else begin
            r_pc   <= n_pc;
            r_cnt  <= n_cnt;
            r_busy <= n_busy;
        end
    end

    assign o_busy      = r_busy;
    assign o_ctrl.step = w_step;
    assign o_ctrl.last = w_last;
    assign o_ctrl.uw   = w_uw;

endmodule

// ===== src/i2cm_datapath.sv =====
// Line levels, shift register, latched request fields and result register.
`timescale 1ns / 1ps
module i2cm_datapath
    import i2cm_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_accept,
    input  logic [2:0] i_req_type,
    input  logic [7:0] i_tx_byte,
    input  logic       i_ack_level,
    input  logic [7:0] i_slave_byte,
    input  logic       i_slave_ack,
    input  t_ctrl      i_ctrl,
    input  logic       i_out_stall,
    output logic       o_slot_free,
    output logic       o_out_valid,
    output logic       o_scl_out,
    output logic       o_sda_out,
    output logic       o_run_last,
    output logic [7:0] o_rx_data,
    output logic       o_rx_ack
);

    logic       r_scl, n_scl;
    logic       r_sda, n_sda;
    logic [7:0] r_shift, n_shift;
    logic       r_ack_level;
    logic [7:0] r_slave_byte;
    logic       r_slave_ack;
    logic       r_out_valid;
    logic       r_out_scl, r_out_sda, r_out_last, r_out_rx_ack;
    logic [7:0] r_out_rx_data;
    logic [CNT_W-1:0] r_bit_idx;

    // Read sample index tracks the loop count, MSB first.
    logic [CNT_W-1:0] n_bit_idx;

    assign o_slot_free = !r_out_valid || !i_out_stall;

    always_comb begin
        n_scl     = r_scl;
        n_sda     = r_sda;
        n_shift   = r_shift;
        n_bit_idx = r_bit_idx;
        if (i_accept) begin
            n_bit_idx = BIT_CNT_INIT;
            if (i_req_type == CMD_WRITE)
                n_shift = i_tx_byte;
            else if (i_req_type == CMD_READ)
                n_shift = '0;
        end else if (i_ctrl.step) begin
            unique case (i_ctrl.uw.scl_op)
                SCL_LOW:  n_scl = 1'b0;
                SCL_HIGH: n_scl = 1'b1;
                default:  n_scl = r_scl;
            endcase
            unique case (i_ctrl.uw.sda_op)
                SDA_LOW:  n_sda = 1'b0;
                SDA_HIGH: n_sda = 1'b1;
                SDA_ACK:  n_sda = r_ack_level;
                SDA_MSB:  n_sda = r_shift[7];
                default:  n_sda = r_sda;
            endcase
            case (i_ctrl.uw.shift_op)
                SH_LEFT: n_shift = {r_shift[6:0], 1'b0};
                SH_IN: begin
                    n_shift   = {r_shift[6:0], r_slave_byte[r_bit_idx]};
                    n_bit_idx = CNT_W'(r_bit_idx - 1'b1);
                end
                default: n_shift = r_shift;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scl       <= 1'b1;
            r_sda       <= 1'b1;
            r_shift     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_scl   <= n_scl;
            r_sda   <= n_sda;
            r_shift <= n_shift;
            if (i_ctrl.step)
                r_out_valid <= 1'b1;
            else if (!i_out_stall)
                r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_bit_idx <= n_bit_idx;
        if (i_accept) begin
            r_ack_level  <= i_ack_level;
            r_slave_byte <= i_slave_byte;
            r_slave_ack  <= i_slave_ack;
        end
        if (i_ctrl.step) begin
            r_out_scl     <= n_scl;
            r_out_sda     <= n_sda;
            r_out_last    <= i_ctrl.last;
            r_out_rx_data <= (i_ctrl.last && i_ctrl.uw.rx_byte) ? n_shift : 8'h00;
            r_out_rx_ack  <= i_ctrl.last && i_ctrl.uw.rx_ack && r_slave_ack;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_scl_out   = r_out_scl;
    assign o_sda_out   = r_out_sda;
    assign o_run_last  = r_out_last;
    assign o_rx_data   = r_out_rx_data;
    assign o_rx_ack    = r_out_rx_ack;

endmodule

// ===== src/i2c_master_bit_engine.sv =====
// Each request steps through n line phases (n = 4 start, 3 stop, 24 write, 17 read, 3 send ack,
// 3 read ack); each phase is registered into the output registers, and output stall pauses the steps.
// A new request is taken the cycle after the last phase of the previous one is issued, not before.
// Unknown request codes are accepted without starting a run and produce no results.
// Reset (synchronous, active low): SCL and SDA released high, shift register cleared, idle.
`timescale 1ns / 1ps
module i2c_master_bit_engine
    import i2cm_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [2:0] i_req_type,
    input  logic [7:0] i_tx_byte,
    input  logic       i_ack_level,
    input  logic [7:0] i_slave_byte,
    input  logic       i_slave_ack,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic       o_scl_out,
    output logic       o_sda_out,
    output logic       o_run_last,
    output logic [7:0] o_rx_data,
    output logic       o_rx_ack
);

`include "i2c_master_bit_engine_assert.svh"

    logic  w_busy;
    logic  w_accept;
    logic  w_launch;
    logic  w_slot_free;
    t_ctrl w_ctrl;

    assign o_in_stall = w_busy;
    assign w_accept   = i_in_valid && !w_busy;
    assign w_launch   = w_accept && cmd_known(i_req_type);

    i2cm_sequencer u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_launch    (w_launch),
        .i_cmd       (i_req_type),
        .i_slot_free (w_slot_free),
        .o_busy      (w_busy),
        .o_ctrl      (w_ctrl)
    );

    i2cm_datapath u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (w_accept),
        .i_req_type   (i_req_type),
        .i_tx_byte    (i_tx_byte),
        .i_ack_level  (i_ack_level),
        .i_slave_byte (i_slave_byte),
        .i_slave_ack  (i_slave_ack),
        .i_ctrl       (w_ctrl),
        .i_out_stall  (i_out_stall),
        .o_slot_free  (w_slot_free),
        .o_out_valid  (o_out_valid),
        .o_scl_out    (o_scl_out),
        .o_sda_out    (o_sda_out),
        .o_run_last   (o_run_last),
        .o_rx_data    (o_rx_data),
        .o_rx_ack     (o_rx_ack)
    );

    `I2CM_ASSERT_NXT(a_last_ends_run, i_clk, i_rst_n, w_ctrl.step && w_ctrl.last, !w_busy)
    `I2CM_ASSERT_NXT(a_launch_busy, i_clk, i_rst_n, w_launch, w_busy && o_in_stall)
    `I2CM_ASSERT_IMP(a_rx_on_last, i_clk, i_rst_n,
        o_out_valid && ((o_rx_data != 8'h00) || o_rx_ack), o_run_last)

endmodule
